[design/assert_macros.svh]
// Assertion macros shared by the fingerprint monitor RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every rising edge outside reset
`define IWFM_ASSERT(lbl, clk_sig, rst_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error("iwfm assertion failed");

// cond must never be true at a rising edge outside reset
`define IWFM_NEVER(lbl, clk_sig, rst_sig, cond) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) !(cond)) \
        else $error("iwfm forbidden condition seen");

`else

`define IWFM_ASSERT(lbl, clk_sig, rst_sig, prop)
`define IWFM_NEVER(lbl, clk_sig, rst_sig, cond)

`endif

`endif

[design/iwfm_pkg.sv]
// Shared constants and types of the I/O workload fingerprint monitor.
// No dependencies; imported by every module of the block.
package iwfm_pkg;

    localparam int ID_SLOTS = 16;
    localparam int SLOT_W   = $clog2(ID_SLOTS);

    localparam int THR_W  = 10;
    localparam int PID_W  = 22;
    localparam int CNT_W  = 32;
    localparam int SCNT_W = 16;
    localparam int SEC_W  = 48;
    localparam int TS_W   = 64;
    localparam int SUM_W  = 64;
    localparam int TOT_W  = 32;
    localparam int OSLOT_W = 4;

    localparam logic [THR_W-1:0] THR_RESET = 10'd10;

    localparam int IN_TDATA_W  = 184;
    localparam int OUT_TDATA_W = 296;

    typedef struct packed {
        logic              start;
        logic              is_write;
        logic [SCNT_W-1:0] sector_count;
        logic [TS_W-1:0]   timestamp;
        logic [SEC_W-1:0]  start_sector;
    } stat_req_t;

    typedef struct packed {
        logic [TOT_W-1:0] read_total;
        logic [TOT_W-1:0] write_total;
        logic [SUM_W-1:0] sector_total;
        logic [SUM_W-1:0] time_total;
        logic [SUM_W-1:0] distance_total;
    } stat_totals_t;

    typedef struct packed {
        logic             start;
        logic             qualify;
        logic [PID_W-1:0] id;
    } set_req_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] top_slot;
    } set_stat_t;

endpackage

[design/io_workload_fingerprint_monitor_unit.sv]
// A request passes from accept through start_reg, the stats and id set units and the
// done flags to T_FIN and the output register; an id search, when it runs, reads the
// slot memory one entry per cycle over the filled slots above slot 0. One request is in
// flight at a time: s_tready is low until T_FIN loads the output, which waits for room.
// Reset: rst_n asynchronous, active low; clears all totals, the id set
// (slot 0 holds id 0) and sets the id count threshold to 10.
`include "assert_macros.svh"

module io_workload_fingerprint_monitor_unit
    import iwfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // sector_count, timestamp, start_sector, process_id, process_tagged,
    // process_io_count, zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // is_write
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_total, write_total, sector_total, time_total, distance_total,
    // last_id_slot, new_process_io_count, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [THR_W-1:0]       cfg_wr_data
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_FIN
    } top_state_t;

    top_state_t             state_reg;
    logic                   start_reg;
    logic                   stats_done_reg;
    logic                   set_done_reg;
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [THR_W-1:0]       thr_reg;

    logic                   in_write_reg;
    logic [SCNT_W-1:0]      in_scnt_reg;
    logic [TS_W-1:0]        in_ts_reg;
    logic [SEC_W-1:0]       in_sector_reg;
    logic [PID_W-1:0]       in_pid_reg;
    logic                   in_tagged_reg;
    logic [CNT_W-1:0]       in_count_reg;

    logic [CNT_W-1:0]       inc_count;
    logic [CNT_W-1:0]       out_count;
    logic                   qualify;
    logic                   accept;
    logic                   out_free;

    stat_req_t              stat_req;
    stat_totals_t           totals;
    logic                   stats_done;
    set_req_t               set_req;
    set_stat_t              set_stat;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == T_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign inc_count = (in_count_reg == '1) ? in_count_reg : in_count_reg + 1'b1;
    assign out_count = in_tagged_reg ? inc_count : in_count_reg;
    assign qualify   = in_tagged_reg && (inc_count >= CNT_W'(thr_reg));

    assign stat_req.start        = start_reg;
    assign stat_req.is_write     = in_write_reg;
    assign stat_req.sector_count = in_scnt_reg;
    assign stat_req.timestamp    = in_ts_reg;
    assign stat_req.start_sector = in_sector_reg;

    assign set_req.start   = start_reg;
    assign set_req.qualify = qualify;
    assign set_req.id      = in_pid_reg;

    iwfm_stats u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (stat_req),
        .done   (stats_done),
        .totals (totals)
    );

    iwfm_idset u_idset (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (set_req),
        .stat  (set_stat)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_write_reg  <= s_tuser;
            in_scnt_reg   <= s_tdata[15:0];
            in_ts_reg     <= s_tdata[79:16];
            in_sector_reg <= s_tdata[127:80];
            in_pid_reg    <= s_tdata[149:128];
            in_tagged_reg <= s_tdata[150];
            in_count_reg  <= s_tdata[182:151];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_wr_en)
            thr_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            start_reg      <= 1'b0;
            stats_done_reg <= 1'b0;
            set_done_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            start_reg <= accept;
            // in T_FIN the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && (state_reg != T_FIN))
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                        state_reg <= T_RUN;
                end
                T_RUN:
                begin
                    if (stats_done)
                        stats_done_reg <= 1'b1;
                    if (set_stat.done)
                        set_done_reg <= 1'b1;
                    if (stats_done_reg && set_done_reg)
                        state_reg <= T_FIN;
                end
                T_FIN:
                begin
                    // hold the snapshot until the output register frees up
                    if (out_free)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        m_tdata_reg    <= {4'b0, out_count, OSLOT_W'(set_stat.top_slot),
                                           totals.distance_total, totals.time_total,
                                           totals.sector_total, totals.write_total,
                                           totals.read_total};
                        stats_done_reg <= 1'b0;
                        set_done_reg   <= 1'b0;
                        state_reg      <= T_IDLE;
                    end
                end
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `IWFM_ASSERT(a_fin_both_done, clk, rst_n,
        (state_reg == T_FIN) |-> (stats_done_reg && set_done_reg))
    `IWFM_NEVER(a_stats_twice, clk, rst_n, stats_done && stats_done_reg)
    `IWFM_NEVER(a_set_twice, clk, rst_n, set_stat.done && set_done_reg)
    `IWFM_ASSERT(a_accept_starts, clk, rst_n, accept |=> (start_reg && state_reg == T_RUN))

endmodule

[design/iwfm_stats.sv]
// Running request statistics: counts and wrapping sums of sectors,
// inter-arrival time and seek distance. Depends on iwfm_pkg.
module iwfm_stats
    import iwfm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  stat_req_t    req,
    output logic         done,
    output stat_totals_t totals
);

    logic [TOT_W-1:0] reads_reg;
    logic [TOT_W-1:0] writes_reg;
    logic [SUM_W-1:0] sectors_reg;
    logic [TS_W-1:0]  last_time_reg;
    logic [SUM_W-1:0] time_sum_reg;
    logic [SEC_W-1:0] last_head_reg;
    logic [SUM_W-1:0] dist_sum_reg;
    logic             add_reg;
    logic             done_reg;
    logic [SUM_W-1:0] time_step_reg;
    logic [SUM_W-1:0] dist_step_reg;

    logic             time_empty;
    logic             time_newer;
    logic             head_empty;
    logic             head_above;
    logic [SEC_W-1:0] head_diff;

    assign time_empty = (last_time_reg == '0);
    assign time_newer = (req.timestamp >= last_time_reg);
    assign head_empty = (last_head_reg == '0);
    assign head_above = (last_head_reg >= req.start_sector);
    assign head_diff  = head_above ? (last_head_reg - req.start_sector)
                                   : (req.start_sector - last_head_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_reg     <= '0;
            writes_reg    <= '0;
            sectors_reg   <= '0;
            last_time_reg <= '0;
            time_sum_reg  <= '0;
            last_head_reg <= '0;
            dist_sum_reg  <= '0;
            add_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            add_reg  <= req.start;
            done_reg <= add_reg;
            if (req.start)
            begin
                if (req.is_write)
                    writes_reg <= writes_reg + 1'b1;
                else
                    reads_reg <= reads_reg + 1'b1;
                sectors_reg <= sectors_reg + SUM_W'(req.sector_count);
                // an older stamp leaves the time mark alone
                if (time_empty || time_newer)
                    last_time_reg <= req.timestamp;
                last_head_reg <= req.start_sector;
            end
            if (add_reg)
            begin
                time_sum_reg <= time_sum_reg + time_step_reg;
                dist_sum_reg <= dist_sum_reg + dist_step_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            time_step_reg <= (!time_empty && time_newer)
                             ? (req.timestamp - last_time_reg) : '0;
            dist_step_reg <= head_empty ? '0 : SUM_W'(head_diff);
        end
    end

    assign done                  = done_reg;
    assign totals.read_total     = reads_reg;
    assign totals.write_total    = writes_reg;
    assign totals.sector_total   = sectors_reg;
    assign totals.time_total     = time_sum_reg;
    assign totals.distance_total = dist_sum_reg;

endmodule

[design/iwfm_idset.sv]
// Bounded set of recorded process ids, kept in a one-port-read memory
// and searched one slot per cycle. Depends on iwfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iwfm_idset
    import iwfm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  set_req_t  req,
    output set_stat_t stat
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } set_state_t;

    set_state_t        state_reg;
    logic [SLOT_W-1:0] top_reg;
    logic [SLOT_W:0]   addr_reg;
    logic              pend_reg;
    logic              done_reg;

    logic [PID_W-1:0]  slot_mem [ID_SLOTS];
    logic [PID_W-1:0]  rdata_reg;

    logic              hit;
    logic              more;
    logic              not_full;
    logic              rd_en;
    logic              mem_we;
    logic [SLOT_W-1:0] wr_addr;
    logic              done_next;

    // slot 0 holds id 0 for good and is never read or written
    assign hit      = pend_reg && (rdata_reg == req.id);
    assign more     = (addr_reg <= {1'b0, top_reg});
    assign not_full = (top_reg != SLOT_W'(ID_SLOTS - 1));
    assign rd_en    = (state_reg == S_SCAN) && !hit && more;
    assign mem_we   = (state_reg == S_SCAN) && !hit && !more && not_full;
    assign wr_addr  = SLOT_W'(top_reg + 1'b1);

    // finish at once when no search is needed, else when the search ends
    assign done_next = ((state_reg == S_IDLE) && req.start
                        && !(req.qualify && (req.id != '0)))
                       || ((state_reg == S_SCAN) && (hit || !more));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[wr_addr] <= req.id;
        if (rd_en)
            rdata_reg <= slot_mem[addr_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            addr_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.start && req.qualify && (req.id != '0))
                    begin
                        addr_reg  <= (SLOT_W + 1)'(1);
                        pend_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    priority if (hit)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (more)
                    begin
                        addr_reg <= addr_reg + 1'b1;
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        // not found: append unless the set is full
                        if (not_full)
                            top_reg <= wr_addr;
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign stat.done     = done_reg;
    assign stat.top_slot = top_reg;

    `IWFM_ASSERT(a_top_step, clk, rst_n,
        (top_reg != $past(top_reg)) |-> (top_reg == SLOT_W'($past(top_reg) + 1'b1)))
    `IWFM_NEVER(a_done_in_scan, clk, rst_n, (state_reg == S_SCAN) && done_reg)
    `IWFM_NEVER(a_start_busy, clk, rst_n, req.start && (state_reg == S_SCAN))
    `IWFM_NEVER(a_rd_wr_same, clk, rst_n, rd_en && mem_we)

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench for io_workload_fingerprint_monitor_unit: directed and random block I/O
// requests, each snapshot checked field by field against a running statistics model.
// Depends on iwfm_pkg and the unit's RTL.
module testbench;
    import iwfm_pkg::*;

    localparam int DRAIN_CYCLES = ID_SLOTS + 24;
    localparam int LONG_HOLD    = 400;
    localparam int POOL_SIZE    = 24;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [CNT_W-1:0]  io_count;
        logic              tag_bit;
        logic [PID_W-1:0]  pid;
        logic [SEC_W-1:0]  start_sector;
        logic [TS_W-1:0]   timestamp;
        logic [SCNT_W-1:0] sector_count;
    } io_req_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [CNT_W-1:0]   new_count;
        logic [OSLOT_W-1:0] last_id_slot;
        logic [SUM_W-1:0]   distance_total;
        logic [SUM_W-1:0]   time_total;
        logic [SUM_W-1:0]   sector_total;
        logic [TOT_W-1:0]   write_total;
        logic [TOT_W-1:0]   read_total;
    } snapshot_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [THR_W-1:0]       cfg_wr_data = '0;

    // statistics model
    logic [THR_W-1:0]  thr_model;
    logic [TOT_W-1:0]  reads_seen;
    logic [TOT_W-1:0]  writes_seen;
    logic [SUM_W-1:0]  sector_sum;
    logic [TS_W-1:0]   last_stamp;
    logic [SUM_W-1:0]  gap_sum;
    logic [SEC_W-1:0]  last_head;
    logic [SUM_W-1:0]  seek_sum;
    int unsigned       top_slot;
    logic [PID_W-1:0]  id_set [ID_SLOTS];

    snapshot_t         pending_snapshots [$];
    snapshot_t         want_snap;
    snapshot_t         got_snap;

    logic [PID_W-1:0]  pid_pool [POOL_SIZE];
    logic [TS_W-1:0]   stamp_now = '0;
    logic [SEC_W-1:0]  head_now = '0;

    bit                calm = 1'b0;
    bit                long_hold_req = 1'b0;
    int                hold_left = 0;
    int                stall_left = 0;
    int                fail_count = 0;
    int                sent_count = 0;
    int                checked_count = 0;
    int                threshold_writes = 0;

    io_workload_fingerprint_monitor_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic io_req_t make_req(logic [SCNT_W-1:0] sc, logic [TS_W-1:0] ts,
                                         logic [SEC_W-1:0] ss, logic [PID_W-1:0] pid,
                                         logic tag, logic [CNT_W-1:0] cnt);
        io_req_t r;
        r.sector_count = sc;
        r.timestamp    = ts;
        r.start_sector = ss;
        r.pid          = pid;
        r.tag_bit      = tag;
        r.io_count     = cnt;
        return r;
    endfunction

    // Update the running statistics with one request and return its snapshot.
    function automatic snapshot_t advance_stats(logic wr, io_req_t r);
        snapshot_t        s;
        logic [CNT_W-1:0] cnt;
        logic [SEC_W-1:0] seek;
        bit               known;
        cnt = r.io_count;
        if (wr)
            writes_seen++;
        else
            reads_seen++;
        sector_sum += r.sector_count;
        // zero mark means capture only; older stamps are dropped
        if (last_stamp == 0)
            last_stamp = r.timestamp;
        else if (r.timestamp >= last_stamp)
        begin
            gap_sum += r.timestamp - last_stamp;
            last_stamp = r.timestamp;
        end
        if (last_head == 0)
            last_head = r.start_sector;
        else
        begin
            seek = (last_head >= r.start_sector) ? last_head - r.start_sector
                                                 : r.start_sector - last_head;
            seek_sum += seek;
            last_head = r.start_sector;
        end
        if (r.tag_bit)
        begin
            if (cnt != '1)
                cnt++;
            if (cnt >= thr_model)
            begin
                known = 1'b0;
                for (int i = 0; i <= top_slot; i++)
                    if (id_set[i] == r.pid)
                        known = 1'b1;
                if (!known && top_slot < ID_SLOTS - 1)
                begin
                    top_slot++;
                    id_set[top_slot] = r.pid;
                end
            end
        end
        s.read_total     = reads_seen;
        s.write_total    = writes_seen;
        s.sector_total   = sector_sum;
        s.time_total     = gap_sum;
        s.distance_total = seek_sum;
        s.last_id_slot   = OSLOT_W'(top_slot);
        s.new_count      = cnt;
        return s;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one request, optionally after an idle burst, and hold it until accepted.
    task automatic send_request(logic wr, io_req_t r);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r};
        s_tuser  <= wr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_snapshots.push_back(advance_stats(wr, r));
        sent_count++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_snapshots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        thr_model = value;
        threshold_writes++;
    endtask

    // Mostly well-formed traffic: rising stamps, nearby sectors, recurring ids.
    task automatic random_requests(int n);
        io_req_t       r;
        logic          wr;
        int            k;
        logic [TS_W:0] ahead;
        repeat (n)
        begin
            wr = 1'($urandom_range(0, 1));
            k = $urandom_range(0, 15);
            if (k == 0)
                r.sector_count = '1;
            else if (k < 10)
                r.sector_count = SCNT_W'($urandom_range(1, 256));
            else
                r.sector_count = SCNT_W'($urandom);

            k = $urandom_range(0, 19);
            if (k == 0 && stamp_now != 0)
                r.timestamp = rand64() % stamp_now;
            else
            begin
                ahead = stamp_now + ((k == 1) ? $urandom : $urandom_range(0, 5000));
                if (!ahead[TS_W])
                    stamp_now = ahead[TS_W-1:0];
                r.timestamp = stamp_now;
            end

            k = $urandom_range(0, 9);
            if (k == 0)
                head_now = '0;
            else if (k < 4)
                head_now = SEC_W'(rand64());
            else if (k < 6)
                head_now = head_now - $urandom_range(0, 4096);
            else
                head_now = head_now + r.sector_count;
            r.start_sector = head_now;

            r.pid = ($urandom_range(0, 3) == 0) ? PID_W'($urandom)
                                                : pid_pool[$urandom_range(0, POOL_SIZE - 1)];
            r.tag_bit = ($urandom_range(0, 9) < 6);
            k = $urandom_range(0, 7);
            if (k == 0)
                r.io_count = '1;
            else if (k == 1)
                r.io_count = $urandom;
            else
                r.io_count = $urandom_range(0, thr_model + 16);
            send_request(wr, r);
        end
    endtask

    task automatic test_first_requests();
        send_request(1'b0, make_req('0, '0, '0, '0, 1'b0, '0));
        send_request(1'b1, make_req('1, 64'd100, 48'd1000, '1, 1'b1, 32'd9));
        send_request(1'b0, make_req(16'd1, 64'd250, 48'd200, '1, 1'b1, 32'd50));
        send_request(1'b1, make_req(16'd7, 64'd300, '1, 22'd5, 1'b1, 32'd8));
    endtask

    task automatic test_time_marks();
        send_request(1'b0, make_req(16'd3, 64'd200, 48'd77, 22'd6, 1'b0, 32'd1));
        send_request(1'b1, make_req(16'd3, 64'd300, 48'd78, 22'd6, 1'b0, 32'd1));
        send_request(1'b0, make_req(16'd3, 64'd1000, 48'd90, 22'd6, 1'b0, 32'd1));
    endtask

    task automatic test_head_marks();
        // a request at sector 0 empties the head mark, the next one only captures
        send_request(1'b1, make_req(16'd8, 64'd1100, '0, 22'd6, 1'b0, 32'd2));
        send_request(1'b0, make_req(16'd8, 64'd1200, 48'd500, 22'd6, 1'b0, 32'd2));
        send_request(1'b1, make_req(16'd8, 64'd1300, 48'd400, 22'd6, 1'b0, 32'd2));
    endtask

    task automatic test_count_limits();
        send_request(1'b0, make_req(16'd2, 64'd1400, 48'd410, 22'd7, 1'b1, '1));
        send_request(1'b1, make_req(16'd2, 64'd1500, 48'd420, 22'd8, 1'b0, '1));
        send_request(1'b0, make_req(16'd2, 64'd1600, 48'd430, 22'd9, 1'b0, 32'd1000));
    endtask

    task automatic test_threshold_extremes();
        set_threshold('0);
        send_request(1'b1, make_req(16'd4, 64'd1700, 48'd440, 22'd11, 1'b1, '0));
        send_request(1'b0, make_req(16'd4, 64'd1800, 48'd450, '0, 1'b1, '0));
        set_threshold('1);
        send_request(1'b1, make_req(16'd4, 64'd1900, 48'd460, 22'd12, 1'b1, 32'd1021));
        send_request(1'b0, make_req(16'd4, 64'd2000, 48'd470, 22'd12, 1'b1, 32'd1022));
        send_request(1'b1, make_req(16'd4, 64'd2100, 48'd480, 22'd13, 1'b0, 32'd5000));
        set_threshold(THR_RESET);
        stamp_now = 64'd2100;
        head_now  = 48'd480;
    endtask

    task automatic test_backpressure();
        calm = 1'b1;
        long_hold_req = 1'b1;
        random_requests(40);
        calm = 1'b0;
    endtask

    task automatic test_random_mix();
        logic [THR_W-1:0] settings [5];
        settings = '{THR_W'($urandom_range(1, 1022)), '0, '1,
                     THR_W'($urandom_range(1, 40)), THR_RESET};
        foreach (settings[i])
        begin
            set_threshold(settings[i]);
            random_requests(240);
        end
    endtask

    task automatic test_id_set_full();
        set_threshold('0);
        // fill every slot, then offer new ids that must be turned away
        while (top_slot < ID_SLOTS - 1)
            random_tagged_new_id();
        repeat (3) random_tagged_new_id();
    endtask

    task automatic random_tagged_new_id();
        stamp_now += 64'd10;
        head_now  += 48'd64;
        send_request(1'($urandom_range(0, 1)),
                     make_req(SCNT_W'($urandom), stamp_now, head_now,
                              PID_W'($urandom), 1'b1, $urandom));
    endtask

    task automatic test_high_stamps();
        calm = 1'b1;
        // lift the time base so the upper stamp bits see traffic
        stamp_now = {4'hF, 60'(rand64() >> 8)};
        set_threshold(THR_W'($urandom_range(0, 1023)));
        random_requests(250);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_snapshots.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                fail_count++;
            end
            else
            begin
                want_snap = pending_snapshots.pop_front();
                got_snap  = m_tdata[$bits(snapshot_t)-1:0];
                check_field("read_total", want_snap.read_total, got_snap.read_total);
                check_field("write_total", want_snap.write_total, got_snap.write_total);
                check_field("sector_total", want_snap.sector_total, got_snap.sector_total);
                check_field("time_total", want_snap.time_total, got_snap.time_total);
                check_field("distance_total", want_snap.distance_total,
                            got_snap.distance_total);
                check_field("last_id_slot", want_snap.last_id_slot, got_snap.last_id_slot);
                check_field("new_process_io_count", want_snap.new_count, got_snap.new_count);
                checked_count++;
            end
        end
    end

    // receiver: long hold on request, otherwise random stall bursts unless calm
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        thr_model   = THR_RESET;
        reads_seen  = '0;
        writes_seen = '0;
        sector_sum  = '0;
        last_stamp  = '0;
        gap_sum     = '0;
        last_head   = '0;
        seek_sum    = '0;
        top_slot    = 0;
        foreach (id_set[i])
            id_set[i] = '0;
        foreach (pid_pool[i])
            pid_pool[i] = PID_W'($urandom);
        pid_pool[0] = '0;
        pid_pool[1] = '1;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_requests();
        test_time_marks();
        test_head_marks();
        test_count_limits();
        test_threshold_extremes();
        test_backpressure();
        test_random_mix();
        test_id_set_full();
        test_high_stamps();
        wait_idle();

        $display("Checked %0d snapshots from %0d requests across %0d threshold writes.",
                 checked_count, sent_count, threshold_writes);
        $display("Id set ended at slot %0d, including a long receiver hold and a full set.",
                 top_slot);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
